### hw/rtl/sbpf_pkg.sv
// Shared types, constants and CRC table function for the servo bus packet framer.
`default_nettype none

package sbpf_pkg;

    localparam logic        OP_WRITE    = 1'b0;
    localparam logic        OP_READ     = 1'b1;

    localparam logic [15:0] CRC_POLY    = 16'h8005;
    localparam logic [15:0] WRITE_MAX   = 16'd65530;
    localparam logic [15:0] WRITE_EXTRA = 16'd5;
    localparam logic [15:0] READ_LEN    = 16'd7;

    localparam logic [7:0]  HDR_SYNC    = 8'hFF;
    localparam logic [7:0]  HDR_MARK    = 8'hFD;
    localparam logic [7:0]  HDR_RSVD    = 8'h00;
    localparam logic [7:0]  INSTR_WRITE = 8'h03;
    localparam logic [7:0]  INSTR_READ  = 8'h02;

    // Byte position within one held item's output sequence
    localparam logic [3:0]  STEP_SYNC0  = 4'd0;
    localparam logic [3:0]  STEP_SYNC1  = 4'd1;
    localparam logic [3:0]  STEP_MARK   = 4'd2;
    localparam logic [3:0]  STEP_RSVD   = 4'd3;
    localparam logic [3:0]  STEP_ID     = 4'd4;
    localparam logic [3:0]  STEP_LEN_LO = 4'd5;
    localparam logic [3:0]  STEP_LEN_HI = 4'd6;
    localparam logic [3:0]  STEP_INSTR  = 4'd7;
    localparam logic [3:0]  STEP_ADR_LO = 4'd8;
    localparam logic [3:0]  STEP_ADR_HI = 4'd9;
    localparam logic [3:0]  STEP_DATA   = 4'd10;  // read: count low
    localparam logic [3:0]  STEP_WCRC_L = 4'd11;  // read: count high
    localparam logic [3:0]  STEP_WCRC_H = 4'd12;  // read: crc low
    localparam logic [3:0]  STEP_RCRC_H = 4'd13;

    typedef struct packed {
        logic        op;
        logic [7:0]  servo_id;
        logic [15:0] reg_addr;
        logic [15:0] word;      // write: length field, read: requested count
        logic [7:0]  data_byte;
        logic        last;      // write: this item closes the packet
        logic [3:0]  step;
    } item_t;

    typedef struct packed {
        logic adv;
        logic done;
    } emit_ctl_t;

    function automatic logic [15:0] crc_table(input logic [7:0] idx);
        logic [15:0] c;
        c = {idx, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        return {crc[7:0], 8'h00} ^ crc_table(crc[15:8] ^ b);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sbpf_hold.sv
// Input holding register and packet tracking state (open packet, bytes left).
`default_nettype none

module sbpf_hold (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  op,
    input  wire  [7:0]           servo_id,
    input  wire  [15:0]          reg_addr,
    input  wire  [15:0]          count,
    input  wire  [7:0]           data_byte,
    input  sbpf_pkg::emit_ctl_t  ctl,
    output logic                 hold_valid,
    output sbpf_pkg::item_t      item
);
    import sbpf_pkg::*;

    logic        hold_valid_reg;
    logic [3:0]  step_reg;
    logic        in_packet_reg, in_packet_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    item_t       item_reg, item_next;
    logic        accept;
    logic [15:0] cnt_clamp;
    logic [15:0] bl_dec;
    logic [3:0]  first_step;

    assign in_ready   = !hold_valid_reg || ctl.done;
    assign accept     = in_valid && in_ready;
    assign hold_valid = hold_valid_reg;

    always_comb
    begin
        if (count == 16'd0)
        begin
            cnt_clamp = 16'd1;
        end
        else if (count > WRITE_MAX)
        begin
            cnt_clamp = WRITE_MAX;
        end
        else
        begin
            cnt_clamp = count;
        end
        bl_dec = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;

        item_next           = item_reg;
        item_next.servo_id  = servo_id;
        item_next.reg_addr  = reg_addr;
        item_next.data_byte = data_byte;
        item_next.step      = STEP_SYNC0;
        in_packet_next      = in_packet_reg;
        bytes_left_next     = bytes_left_reg;
        first_step          = STEP_SYNC0;

        if (in_packet_reg)
        begin
            // continuation: only the data byte and maybe the crc
            item_next.op    = OP_WRITE;
            item_next.last  = (bl_dec == 16'd0);
            first_step      = STEP_DATA;
            bytes_left_next = bl_dec;
            in_packet_next  = (bl_dec != 16'd0);
        end
        else if (op == OP_READ)
        begin
            item_next.op   = OP_READ;
            item_next.word = count;
            item_next.last = 1'b1;
        end
        else
        begin
            item_next.op    = OP_WRITE;
            item_next.word  = cnt_clamp + WRITE_EXTRA;
            item_next.last  = (cnt_clamp == 16'd1);
            bytes_left_next = cnt_clamp - 16'd1;
            in_packet_next  = (cnt_clamp != 16'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            step_reg       <= STEP_SYNC0;
            in_packet_reg  <= 1'b0;
            bytes_left_reg <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                hold_valid_reg <= 1'b1;
                step_reg       <= first_step;
                in_packet_reg  <= in_packet_next;
                bytes_left_reg <= bytes_left_next;
            end
            else if (ctl.done)
            begin
                hold_valid_reg <= 1'b0;
            end
            else if (ctl.adv)
            begin
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        item      = item_reg;
        item.step = step_reg;
    end

`ifndef SYNTHESIS
    a_idle_no_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        !in_packet_reg |-> bytes_left_reg == 16'd0)
        else $error("bytes left while no packet is open");
    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        accept && hold_valid_reg |-> ctl.done)
        else $error("transaction accepted over a busy holding register");
`endif

endmodule

`default_nettype wire

### hw/rtl/sbpf_emit.sv
// Byte sequencer: selects the next packet byte, runs the CRC and drives the output register.
`default_nettype none

module sbpf_emit (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  hold_valid,
    input  sbpf_pkg::item_t      item,
    output sbpf_pkg::emit_ctl_t  ctl,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [7:0]           tx_byte,
    output logic                 packet_end
);
    import sbpf_pkg::*;

    logic        out_valid_reg;
    logic [7:0]  tx_byte_reg;
    logic        packet_end_reg;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] crc_base;
    logic [7:0]  byte_sel;
    logic        is_crc;
    logic        is_crc_hi;
    logic        final_step;
    logic        adv;

    assign crc_base = (item.step == STEP_SYNC0) ? 16'd0 : crc_reg;

    always_comb
    begin
        unique case (item.step)
            STEP_SYNC0:  byte_sel = HDR_SYNC;
            STEP_SYNC1:  byte_sel = HDR_SYNC;
            STEP_MARK:   byte_sel = HDR_MARK;
            STEP_RSVD:   byte_sel = HDR_RSVD;
            STEP_ID:     byte_sel = item.servo_id;
            STEP_LEN_LO: byte_sel = (item.op == OP_READ) ? READ_LEN[7:0] : item.word[7:0];
            STEP_LEN_HI: byte_sel = (item.op == OP_READ) ? READ_LEN[15:8] : item.word[15:8];
            STEP_INSTR:  byte_sel = (item.op == OP_READ) ? INSTR_READ : INSTR_WRITE;
            STEP_ADR_LO: byte_sel = item.reg_addr[7:0];
            STEP_ADR_HI: byte_sel = item.reg_addr[15:8];
            STEP_DATA:   byte_sel = (item.op == OP_READ) ? item.word[7:0] : item.data_byte;
            STEP_WCRC_L: byte_sel = (item.op == OP_READ) ? item.word[15:8] : crc_reg[7:0];
            STEP_WCRC_H: byte_sel = (item.op == OP_READ) ? crc_reg[7:0] : crc_reg[15:8];
            STEP_RCRC_H: byte_sel = crc_reg[15:8];
            default:     byte_sel = 8'h00;
        endcase
    end

    always_comb
    begin
        if (item.op == OP_READ)
        begin
            is_crc     = (item.step == STEP_WCRC_H) || (item.step == STEP_RCRC_H);
            is_crc_hi  = (item.step == STEP_RCRC_H);
            final_step = (item.step == STEP_RCRC_H);
        end
        else
        begin
            is_crc     = (item.step == STEP_WCRC_L) || (item.step == STEP_WCRC_H);
            is_crc_hi  = (item.step == STEP_WCRC_H);
            final_step = item.last ? (item.step == STEP_WCRC_H) : (item.step == STEP_DATA);
        end
    end

    assign adv      = hold_valid && (!out_valid_reg || out_ready);
    assign ctl.adv  = adv;
    assign ctl.done = adv && final_step;
    assign crc_next = crc_update(crc_base, byte_sel);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            crc_reg       <= 16'd0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= 1'b1;
                if (!is_crc)
                begin
                    crc_reg <= crc_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx_byte_reg    <= byte_sel;
            packet_end_reg <= is_crc_hi;
        end
    end

    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign packet_end = packet_end_reg;

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid |-> item.step <= STEP_RCRC_H)
        else $error("byte step out of range");
    a_write_done_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done && item.op == OP_WRITE |->
            (item.last && item.step == STEP_WCRC_H) || (!item.last && item.step == STEP_DATA))
        else $error("write transaction finished at the wrong byte");
`endif

endmodule

`default_nettype wire

### hw/rtl/servo_bus_packet_framer.sv
// Top level of the servo bus instruction packet framer.
`default_nettype none

// Frames servo bus instruction packets (FF FF FD 00, ID, length, instruction,
// address, parameters, CRC-16/0x8005 low byte first) one byte per output
// transaction. A read packet goes out whole from one input transaction (14 bytes);
// a write packet takes its parameter bytes one per input transaction. The single
// byte lane of the output sequencer sets the rate: each input transaction holds the
// sequencer until all its bytes are out, so write data bytes stream at one per cycle
// while out_ready keeps up; the last data byte yields 3 bytes, a write start 11 (13
// if it is also the last) and a read 14. The next transaction is accepted in the
// cycle the previous one puts out its last byte; the output register reloads in the
// same cycle out_ready takes the byte it holds, so a stalled receiver stalls input.

module servo_bus_packet_framer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         op,
    input  wire  [7:0]  servo_id,
    input  wire  [15:0] reg_addr,
    input  wire  [15:0] count,
    input  wire  [7:0]  data_byte,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [7:0]  tx_byte,
    output logic        packet_end
);
    import sbpf_pkg::*;

    item_t     item;
    emit_ctl_t ctl;
    logic      hold_valid;

    sbpf_hold u_hold (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .servo_id   (servo_id),
        .reg_addr   (reg_addr),
        .count      (count),
        .data_byte  (data_byte),
        .ctl        (ctl),
        .hold_valid (hold_valid),
        .item       (item)
    );

    sbpf_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .item       (item),
        .ctl        (ctl),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tx_byte    (tx_byte),
        .packet_end (packet_end)
    );

endmodule

`default_nettype wire
